// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CHECK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ----- src/jpd_pkg.sv -----
// ---------------------------------------------------------------------------
// jpd_pkg
// shared types, constants and sector boundary tables of the stick quantizer
// ---------------------------------------------------------------------------
package jpd_pkg;

  localparam int SQRT_BITS   = 7;
  localparam int RAD2_W      = 2 * SQRT_BITS;
  localparam int N_BOUNDS    = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0]  DEAD_ZONE   = 7'd15;
  localparam logic [6:0]  MAX_DIST    = 7'd100;
  localparam logic [15:0] MAX_DIST_SQ = 16'd10000;

  localparam logic [3:0] DIR_NONE       = 4'd0;
  localparam logic [3:0] DIR_RIGHT      = 4'd1;
  localparam logic [3:0] DIR_RIGHT_FWD  = 4'd2;
  localparam logic [3:0] DIR_FWD        = 4'd3;
  localparam logic [3:0] DIR_LEFT_FWD   = 4'd4;
  localparam logic [3:0] DIR_LEFT       = 4'd5;
  localparam logic [3:0] DIR_LEFT_BACK  = 4'd6;
  localparam logic [3:0] DIR_BACK       = 4'd7;
  localparam logic [3:0] DIR_RIGHT_BACK = 4'd8;

  typedef struct packed {
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } sample_t;

  typedef struct packed {
    logic [6:0] distance;
    logic [3:0] direction;
  } result_t;

  typedef struct packed {
    logic signed [7:0] x;
    logic [7:0]        v;
    logic              neg;
    logic              big;
    logic [RAD2_W-1:0] rad2;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // upper half plane first, then lower half plane, selected by the neg bit
  localparam logic signed [40:0] BOUND_C [16] = '{
     41'sd984807753012,  41'sd965925826289,  41'sd258819045103,  41'sd173648177667,
    -41'sd342020143326, -41'sd422618261741, -41'sd965925826289, -41'sd984807753012,
     41'sd981627183448,  41'sd961261695938,  41'sd241921895600,  41'sd156434465040,
    -41'sd190808995377, -41'sd275637355817, -41'sd970295726276, -41'sd987688340595
  };

  localparam logic signed [40:0] BOUND_S [16] = '{
     41'sd173648177667,  41'sd258819045103,  41'sd965925826289,  41'sd984807753012,
     41'sd939692620786,  41'sd906307787037,  41'sd258819045103,  41'sd173648177667,
     41'sd190808995377,  41'sd275637355817,  41'sd970295726276,  41'sd987688340595,
     41'sd981627183448,  41'sd961261695938,  41'sd241921895600,  41'sd156434465040
  };

endpackage

// ----- src/joystick_polar_direction.sv -----
// ---------------------------------------------------------------------------
// joystick_polar_direction
// stick position to clamped radius and eight-way direction with dead zone
// ---------------------------------------------------------------------------
// sample channel: one stick position (stick_x, stick_y) per word, taken at a
//   clock edge with sample_valid high and sample_stall low
// result channel: one word per sample, distance and direction, in order,
//   held stable while result_stall is high
// a sample passes the queue, the eight back stages and the result register
// throughput: one sample per cycle without result stalls, set by the
//   eight back stages: a sector boundary each, a root bit in all but the last
// a two word queue parts the front classifier from the back pipeline;
//   sample_stall rises only when that queue is full
// when the receiver stalls the whole back pipeline holds, the queue fills
//   and then sample_stall goes high
// reset (rst, synchronous) empties the queue and the pipeline; no result
//   is pending afterwards
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module joystick_polar_direction #(
  parameter int QUEUE_DEPTH = jpd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  jpd_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output jpd_pkg::result_t result
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  jpd_pkg::cls_t    cls;
  jpd_pkg::cls_t    q_head;
  jpd_pkg::q_stat_t q_stat;
  logic [CNT_W-1:0] q_level;
  logic             push;
  logic             pop;

  assign sample_stall = q_stat.full;
  assign push         = sample_valid && !q_stat.full;

  jpd_front u_front (
    .sample (sample),
    .cls    (cls)
  );

  jpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (cls),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat),
    .level     (q_level)
  );

  jpd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_stat.empty),
    .q_head       (q_head),
    .q_pop        (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `ASSERT_CHECK(a_level_bound, clk, rst, q_level <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
  `ASSERT_CHECK(a_push_count, clk, rst, (push && !pop) |=> (q_level == $past(q_level) + 1'b1), "queue level did not grow on push")
  `ASSERT_CHECK(a_dead_zone, clk, rst, (result_valid && result.distance == '0) |-> (result.direction == jpd_pkg::DIR_NONE), "direction set inside dead zone")

endmodule

// ----- src/jpd_front.sv -----
// ---------------------------------------------------------------------------
// jpd_front
// squares the stick position and folds the lower half plane for the back end
// ---------------------------------------------------------------------------
module jpd_front (
  input  jpd_pkg::sample_t sample,
  output jpd_pkg::cls_t    cls
);

  logic signed [15:0] xx;
  logic signed [15:0] yy;
  logic [15:0]        r2;
  logic               neg;

  always_comb begin
    xx  = sample.stick_x * sample.stick_x;
    yy  = sample.stick_y * sample.stick_y;
    r2  = 16'(xx) + 16'(yy);
    neg = sample.stick_y[7];
    cls.x    = sample.stick_x;
    cls.neg  = neg;
    cls.v    = neg ? (~sample.stick_y + 8'd1) : sample.stick_y;
    cls.big  = (r2 >= jpd_pkg::MAX_DIST_SQ);
    cls.rad2 = r2[jpd_pkg::RAD2_W-1:0];
  end

endmodule

// ----- src/jpd_queue.sv -----
// ---------------------------------------------------------------------------
// jpd_queue
// small fifo between the front classifier and the back pipeline
// ---------------------------------------------------------------------------
module jpd_queue #(
  parameter int DEPTH = jpd_pkg::QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jpd_pkg::cls_t      push_word,
  input  logic               pop,
  output jpd_pkg::cls_t      head,
  output jpd_pkg::q_stat_t   stat,
  output logic [CNT_W-1:0]   level
);

  jpd_pkg::cls_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] level_next;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    level_next  = level;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      level_next = level + 1'b1;
    end else if (pop && !push) begin
      level_next = level - 1'b1;
    end
    head       = mem[rd_ptr];
    stat.full  = (level == CNT_W'(DEPTH));
    stat.empty = (level == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level  <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule

// ----- src/jpd_back.sv -----
// ---------------------------------------------------------------------------
// jpd_back
// eight stage pipeline: one sector boundary test per stage, one root bit in each but the last stage
// ---------------------------------------------------------------------------
module jpd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  jpd_pkg::cls_t    q_head,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_stall,
  output jpd_pkg::result_t result
);

  localparam int NSTAGE = jpd_pkg::N_BOUNDS;
  localparam int SQB    = jpd_pkg::SQRT_BITS;

  typedef struct packed {
    jpd_pkg::cls_t     item;
    logic [SQB-1:0]    root;
    logic [NSTAGE-1:0] hits;
  } stage_t;

  stage_t            stage      [NSTAGE];
  stage_t            stage_in   [NSTAGE];
  stage_t            stage_next [NSTAGE];
  logic [NSTAGE-1:0] stage_valid;
  logic              advance;
  jpd_pkg::result_t  result_next;

  function automatic logic [3:0] sector(input logic [NSTAGE-1:0] a, input logic neg);
    logic [3:0] dir;
    priority if (!a[0]) begin
      dir = jpd_pkg::DIR_RIGHT;
    end else if (a[1] && !a[2]) begin
      dir = neg ? jpd_pkg::DIR_RIGHT_BACK : jpd_pkg::DIR_RIGHT_FWD;
    end else if (a[3] && !a[4]) begin
      dir = neg ? jpd_pkg::DIR_BACK : jpd_pkg::DIR_FWD;
    end else if (a[5] && !a[6]) begin
      dir = neg ? jpd_pkg::DIR_LEFT_BACK : jpd_pkg::DIR_LEFT_FWD;
    end else if (a[7]) begin
      dir = jpd_pkg::DIR_LEFT;
    end else begin
      dir = jpd_pkg::DIR_NONE;
    end
    return dir;
  endfunction

  assign advance = !result_valid || !result_stall;
  assign q_pop   = advance && !q_empty;

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    localparam bit DO_SQRT = (s < SQB);
    localparam int SH      = (s < SQB) ? (SQB - 1 - s) : 0;

    logic signed [40:0]    bc;
    logic signed [40:0]    bs;
    logic signed [49:0]    cv;
    logic signed [49:0]    sx;
    logic signed [49:0]    cross_term;
    logic [SQB-1:0]        t;
    logic [2*SQB-1:0]      sq;

    if (s == 0) begin : g_src
      always_comb begin
        stage_in[s].item = q_head;
        stage_in[s].root = '0;
        stage_in[s].hits = '0;
      end
    end else begin : g_src
      assign stage_in[s] = stage[s-1];
    end

    always_comb begin
      stage_next[s] = stage_in[s];
      bc         = jpd_pkg::BOUND_C[{stage_in[s].item.neg, 3'(s)}];
      bs         = jpd_pkg::BOUND_S[{stage_in[s].item.neg, 3'(s)}];
      cv         = bc * $signed({1'b0, stage_in[s].item.v});
      sx         = bs * $signed(stage_in[s].item.x);
      cross_term = cv - sx;
      stage_next[s].hits[s] = ~cross_term[49];
      t  = stage_in[s].root | (SQB'(1) << SH);
      sq = (2*SQB)'(t) * (2*SQB)'(t);
      if (DO_SQRT && (sq <= stage_in[s].item.rad2)) begin
        stage_next[s].root = t;
      end
    end
  end

  always_comb begin
    logic [6:0] radius;
    radius = stage[NSTAGE-1].item.big ? jpd_pkg::MAX_DIST : stage[NSTAGE-1].root;
    if (radius < jpd_pkg::DEAD_ZONE) begin
      result_next.distance  = '0;
      result_next.direction = jpd_pkg::DIR_NONE;
    end else begin
      result_next.distance  = radius;
      result_next.direction = sector(stage[NSTAGE-1].hits, stage[NSTAGE-1].item.neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      stage_valid  <= {stage_valid[NSTAGE-2:0], !q_empty};
      result_valid <= stage_valid[NSTAGE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < NSTAGE; i++) begin
        stage[i] <= stage_next[i];
      end
      result <= result_next;
    end
  end

endmodule
